FILE: hdl/imu_serial_frame_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// IMU frame decoder assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_DECODER_CORE_ASSERT_SVH
`define IMU_SERIAL_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define ISFD_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ISFD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/isfd_pkg.sv
// ----------------------------------------------------------------------------
// IMU frame decoder package
// Shared constants, frame kind codes and the frame event structure.
// ----------------------------------------------------------------------------
package isfd_pkg;

  localparam int NUM_AXES = 3;
  localparam int SR_W     = 10;
  localparam int ACCEL_W  = 16;
  localparam int ANGLE_W  = 17;
  localparam int RATE_W   = 28;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [3:0] LAST_IDX   = 4'd10;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_ZERO = 1'b1;

  localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 10'd200;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 28'sd131071000;
  localparam logic signed [RATE_W-1:0] RATE_MIN = -28'sd131071000;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_OTHER = 2'd3
  } frame_kind_t;

  typedef struct packed {
    logic                                done;
    frame_kind_t                         kind;
    logic [NUM_AXES-1:0][ACCEL_W-1:0]    code;
  } frame_evt_t;

endpackage

FILE: hdl/isfd_if.sv
// ----------------------------------------------------------------------------
// IMU frame decoder channel interfaces
// Valid/ready channels for input beats, result beats and configuration.
// ----------------------------------------------------------------------------
interface isfd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface isfd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [isfd_pkg::SR_W-1:0]   sample_rate;
  modport source (output valid, sample_rate, input ready);
  modport sink (input valid, sample_rate, output ready);
endinterface

interface isfd_out_if;
  logic                                  valid;
  logic                                  ready;
  isfd_pkg::frame_kind_t                 frame_kind;
  logic signed [isfd_pkg::ACCEL_W-1:0]   accel_x;
  logic signed [isfd_pkg::ACCEL_W-1:0]   accel_y;
  logic signed [isfd_pkg::ACCEL_W-1:0]   accel_z;
  logic signed [isfd_pkg::ANGLE_W-1:0]   angle_x;
  logic signed [isfd_pkg::ANGLE_W-1:0]   angle_y;
  logic signed [isfd_pkg::ANGLE_W-1:0]   angle_z;
  logic signed [isfd_pkg::RATE_W-1:0]    rate_x;
  logic signed [isfd_pkg::RATE_W-1:0]    rate_y;
  logic signed [isfd_pkg::RATE_W-1:0]    rate_z;
  modport source (output valid, frame_kind, accel_x, accel_y, accel_z, angle_x, angle_y,
                  angle_z, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, frame_kind, accel_x, accel_y, accel_z, angle_x, angle_y,
                angle_z, rate_x, rate_y, rate_z, output ready);
endinterface

FILE: hdl/imu_serial_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder core
// Each accepted input beat is held in the input register, its result beat in
// the result register. Throughput: one beat per cycle while out_ch is ready;
// input is taken while a result waits if the input register is empty.
// Reset clears the frame counter, sample_rate (to 200), accel and axis stores.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_core (
  input  logic         clk,
  input  logic         rst_n,
  isfd_in_if.sink      in_ch,
  isfd_cfg_if.sink     cfg_ch,
  isfd_out_if.source   out_ch
);

  `include "imu_serial_frame_decoder_core_assert.svh"

  logic                              item_vld_r;
  logic                              item_mode_r;
  logic [7:0]                        item_byte_r;
  logic                              out_vld_r;
  isfd_pkg::frame_kind_t             kind_r, kind_nxt;
  logic [isfd_pkg::SR_W-1:0]         sample_rate_r;
  logic signed [isfd_pkg::ACCEL_W-1:0] accel_r [isfd_pkg::NUM_AXES];
  logic signed [isfd_pkg::ANGLE_W-1:0] angle_w [isfd_pkg::NUM_AXES];
  logic signed [isfd_pkg::RATE_W-1:0]  rate_w [isfd_pkg::NUM_AXES];

  logic                  advance;
  logic                  proc;
  logic                  byte_en;
  logic                  zero_en;
  logic                  angle_en;
  logic                  accel_en;
  isfd_pkg::frame_evt_t  evt;

  assign advance  = !out_vld_r || out_ch.ready;
  assign proc     = item_vld_r && advance;
  assign byte_en  = proc && (item_mode_r == isfd_pkg::MODE_BYTE);
  assign zero_en  = proc && (item_mode_r == isfd_pkg::MODE_ZERO);
  assign angle_en = evt.done && (evt.kind == isfd_pkg::KIND_ANGLE);
  assign accel_en = evt.done && (evt.kind == isfd_pkg::KIND_ACCEL);
  assign kind_nxt = evt.done ? evt.kind : isfd_pkg::KIND_NONE;

  assign in_ch.ready  = !item_vld_r || advance;
  assign cfg_ch.ready = 1'b1;

  isfd_frame_asm u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (item_byte_r),
    .evt     (evt)
  );

  for (genvar g = 0; g < isfd_pkg::NUM_AXES; g++) begin : g_axis
    isfd_axis u_axis (
      .clk         (clk),
      .rst_n       (rst_n),
      .angle_en    (angle_en),
      .zero_en     (zero_en),
      .code        (evt.code[g]),
      .sample_rate (sample_rate_r),
      .angle       (angle_w[g]),
      .rate        (rate_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r    <= 1'b0;
      out_vld_r     <= 1'b0;
      kind_r        <= isfd_pkg::KIND_NONE;
      sample_rate_r <= isfd_pkg::SAMPLE_RATE_RST;
      for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
        accel_r[i] <= '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        item_vld_r <= 1'b1;
      end else if (proc) begin
        item_vld_r <= 1'b0;
      end
      if (proc) begin
        out_vld_r <= 1'b1;
        kind_r    <= kind_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        sample_rate_r <= cfg_ch.sample_rate;
      end
      if (accel_en) begin
        for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
          accel_r[i] <= evt.code[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_mode_r <= in_ch.mode;
      item_byte_r <= in_ch.rx_byte;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.frame_kind = kind_r;
  assign out_ch.accel_x    = accel_r[0];
  assign out_ch.accel_y    = accel_r[1];
  assign out_ch.accel_z    = accel_r[2];
  assign out_ch.angle_x    = angle_w[0];
  assign out_ch.angle_y    = angle_w[1];
  assign out_ch.angle_z    = angle_w[2];
  assign out_ch.rate_x     = rate_w[0];
  assign out_ch.rate_y     = rate_w[1];
  assign out_ch.rate_z     = rate_w[2];

  `ISFD_ASSERT_NEXT(a_proc_gives_result, proc, out_vld_r, "processed beat gave no result")
  `ISFD_ASSERT_NEXT(a_zero_no_frame, zero_en, kind_r == isfd_pkg::KIND_NONE, "zero-adjust finished a frame")
  `ISFD_ASSERT_IMPL(a_stall_cause, !in_ch.ready, item_vld_r && out_vld_r && !out_ch.ready, "input stalled without a full pipeline")
  `ISFD_ASSERT_IMPL(a_done_needs_byte, evt.done, byte_en, "frame finished without a byte beat")

endmodule

FILE: hdl/isfd_frame_asm.sv
// ----------------------------------------------------------------------------
// IMU frame assembler
// Hunts for the header, collects the 11-byte frame and flags its completion.
// ----------------------------------------------------------------------------
module isfd_frame_asm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            rx_byte,
  output isfd_pkg::frame_evt_t  evt
);

  logic [3:0] count_r;
  logic [3:0] count_nxt;
  logic [7:0] frame_r [1:7];
  logic       take;
  logic       last;

  always_comb begin
    take      = byte_en && ((count_r != 4'd0) || (rx_byte == isfd_pkg::HDR_BYTE));
    last      = take && (count_r == isfd_pkg::LAST_IDX);
    count_nxt = count_r;
    if (last) begin
      count_nxt = 4'd0;
    end else if (take) begin
      count_nxt = count_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= 7; i++) begin
      if (take && (count_r == 4'(i))) begin
        frame_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    evt.done = last;
    if (frame_r[1] == isfd_pkg::TYPE_ACCEL) begin
      evt.kind = isfd_pkg::KIND_ACCEL;
    end else if (frame_r[1] == isfd_pkg::TYPE_ANGLE) begin
      evt.kind = isfd_pkg::KIND_ANGLE;
    end else begin
      evt.kind = isfd_pkg::KIND_OTHER;
    end
    for (int k = 0; k < isfd_pkg::NUM_AXES; k++) begin
      evt.code[k] = {frame_r[3 + 2 * k], frame_r[2 + 2 * k]};
    end
  end

endmodule

FILE: hdl/isfd_axis.sv
// ----------------------------------------------------------------------------
// IMU angle axis
// Holds one axis's zero offset, angle and angular rate.
// ----------------------------------------------------------------------------
module isfd_axis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 angle_en,
  input  logic                                 zero_en,
  input  logic signed [isfd_pkg::ACCEL_W-1:0]  code,
  input  logic [isfd_pkg::SR_W-1:0]            sample_rate,
  output logic signed [isfd_pkg::ANGLE_W-1:0]  angle,
  output logic signed [isfd_pkg::RATE_W-1:0]   rate
);

  localparam int PROD_W = isfd_pkg::ANGLE_W + 1 + isfd_pkg::SR_W + 1;
  localparam logic signed [PROD_W-1:0] PMAX = PROD_W'(isfd_pkg::RATE_MAX);
  localparam logic signed [PROD_W-1:0] PMIN = PROD_W'(isfd_pkg::RATE_MIN);

  logic signed [isfd_pkg::ANGLE_W-1:0] offset_r, offset_nxt;
  logic signed [isfd_pkg::ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [isfd_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic signed [isfd_pkg::ANGLE_W:0]   sum;
  logic signed [isfd_pkg::ANGLE_W:0]   neg;
  logic signed [isfd_pkg::ANGLE_W:0]   diff;
  logic signed [PROD_W-1:0]            prod;

  function automatic logic signed [isfd_pkg::ANGLE_W-1:0] sat_angle(
    input logic signed [isfd_pkg::ANGLE_W:0] v
  );
    logic signed [isfd_pkg::ANGLE_W-1:0] r;
    if (v[isfd_pkg::ANGLE_W] != v[isfd_pkg::ANGLE_W-1]) begin
      r = v[isfd_pkg::ANGLE_W] ? {1'b1, {(isfd_pkg::ANGLE_W-1){1'b0}}}
                               : {1'b0, {(isfd_pkg::ANGLE_W-1){1'b1}}};
    end else begin
      r = v[isfd_pkg::ANGLE_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    sum       = (isfd_pkg::ANGLE_W+1)'(code) + (isfd_pkg::ANGLE_W+1)'(offset_r);
    angle_nxt = sat_angle(sum);
    diff      = (isfd_pkg::ANGLE_W+1)'(angle_nxt) - (isfd_pkg::ANGLE_W+1)'(angle_r);
    prod      = PROD_W'(diff) * $signed(PROD_W'({1'b0, sample_rate}));
    if (prod > PMAX) begin
      rate_nxt = isfd_pkg::RATE_MAX;
    end else if (prod < PMIN) begin
      rate_nxt = isfd_pkg::RATE_MIN;
    end else begin
      rate_nxt = prod[isfd_pkg::RATE_W-1:0];
    end
    neg        = -((isfd_pkg::ANGLE_W+1)'(angle_r));
    offset_nxt = sat_angle(neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      angle_r  <= '0;
      rate_r   <= '0;
    end else begin
      if (zero_en) begin
        offset_r <= offset_nxt;
      end
      if (angle_en) begin
        angle_r <= angle_nxt;
        rate_r  <= rate_nxt;
      end
    end
  end

  assign angle = angle_r;
  assign rate  = rate_r;

endmodule

FILE: bench/tb_imu_serial_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder core testbench
// Feeds header hunting noise, acceleration, angle and unknown-type frames and
// zero-adjust beats under several sample rates, with random gaps on the input
// and random stalls on the result channel. A scoreboard predicts every result
// beat from the accepted input beats and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_imu_serial_frame_decoder_core;

  localparam int FRAME_LEN = int'(isfd_pkg::LAST_IDX) + 1;
  localparam longint ANGLE_HI = (longint'(1) << (isfd_pkg::ANGLE_W - 1)) - 1;
  localparam longint ANGLE_LO = -(longint'(1) << (isfd_pkg::ANGLE_W - 1));
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_BEATS = 190;
  localparam int NUM_RATES = 5;

  typedef struct packed {
    isfd_pkg::frame_kind_t                                      kind;
    logic [isfd_pkg::NUM_AXES-1:0][isfd_pkg::ACCEL_W-1:0]       accel;
    logic [isfd_pkg::NUM_AXES-1:0][isfd_pkg::ANGLE_W-1:0]       angle;
    logic [isfd_pkg::NUM_AXES-1:0][isfd_pkg::RATE_W-1:0]        rate;
  } imu_sample_t;

  class imu_scoreboard;
    logic [isfd_pkg::SR_W-1:0] rate_cfg;
    int              frame_pos;
    logic [7:0]      frame_buf [FRAME_LEN];
    longint          accel_st [isfd_pkg::NUM_AXES];
    longint          angle_st [isfd_pkg::NUM_AXES];
    longint          prev_st [isfd_pkg::NUM_AXES];
    longint          offset_st [isfd_pkg::NUM_AXES];
    longint          rate_st [isfd_pkg::NUM_AXES];
    imu_sample_t     sample_q [$];
    int              mismatches;

    function new();
      rate_cfg = isfd_pkg::SAMPLE_RATE_RST;
      frame_pos = 0;
      mismatches = 0;
      for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
        accel_st[i] = 0;
        angle_st[i] = 0;
        prev_st[i] = 0;
        offset_st[i] = 0;
        rate_st[i] = 0;
      end
    endfunction

    function void set_rate(logic [isfd_pkg::SR_W-1:0] v);
      rate_cfg = v;
    endfunction

    function int pending();
      return sample_q.size();
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint code_at(int k);
      logic signed [isfd_pkg::ACCEL_W-1:0] c;
      c = {frame_buf[k+1], frame_buf[k]};
      return longint'(c);
    endfunction

    function void note_input(logic mode, logic [7:0] b);
      imu_sample_t e;
      isfd_pkg::frame_kind_t k;
      longint a;
      k = isfd_pkg::KIND_NONE;
      if (mode == isfd_pkg::MODE_ZERO) begin
        for (int i = 0; i < isfd_pkg::NUM_AXES; i++)
          offset_st[i] = clip(-angle_st[i], ANGLE_LO, ANGLE_HI);
      end else if (frame_pos != 0 || b == isfd_pkg::HDR_BYTE) begin
        frame_buf[frame_pos] = b;
        frame_pos++;
        if (frame_pos == FRAME_LEN) begin
          frame_pos = 0;
          if (frame_buf[1] == isfd_pkg::TYPE_ACCEL) begin
            k = isfd_pkg::KIND_ACCEL;
            for (int i = 0; i < isfd_pkg::NUM_AXES; i++) accel_st[i] = code_at(2 + 2 * i);
          end else if (frame_buf[1] == isfd_pkg::TYPE_ANGLE) begin
            k = isfd_pkg::KIND_ANGLE;
            for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
              a = clip(code_at(2 + 2 * i) + offset_st[i], ANGLE_LO, ANGLE_HI);
              rate_st[i] = clip((a - prev_st[i]) * longint'(rate_cfg),
                                longint'(isfd_pkg::RATE_MIN), longint'(isfd_pkg::RATE_MAX));
              angle_st[i] = a;
              prev_st[i] = a;
            end
          end else begin
            k = isfd_pkg::KIND_OTHER;
          end
        end
      end
      e.kind = k;
      for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
        e.accel[i] = accel_st[i][isfd_pkg::ACCEL_W-1:0];
        e.angle[i] = angle_st[i][isfd_pkg::ANGLE_W-1:0];
        e.rate[i] = rate_st[i][isfd_pkg::RATE_W-1:0];
      end
      sample_q.push_back(e);
    endfunction

    function void check_result(imu_sample_t got);
      imu_sample_t e;
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: unexpected result beat, kind %0d", got.kind);
        return;
      end
      e = sample_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: kind exp %0d got %0d", e.kind, got.kind);
          for (int i = 0; i < isfd_pkg::NUM_AXES; i++)
            $display("  axis %0d accel exp %0d got %0d, angle exp %0d got %0d, %s",
                     i, $signed(e.accel[i]), $signed(got.accel[i]),
                     $signed(e.angle[i]), $signed(got.angle[i]),
                     $sformatf("rate exp %0d got %0d",
                               $signed(e.rate[i]), $signed(got.rate[i])));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   in_quiet;
  int   out_quiet;
  logic [isfd_pkg::SR_W-1:0] rate_plan [NUM_RATES];
  imu_scoreboard sb;

  isfd_in_if  in_ch ();
  isfd_cfg_if cfg_ch ();
  isfd_out_if out_ch ();

  imu_serial_frame_decoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h5555;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    imu_sample_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.frame_kind;
        got.accel = {out_ch.accel_z, out_ch.accel_y, out_ch.accel_x};
        got.angle = {out_ch.angle_z, out_ch.angle_y, out_ch.angle_x};
        got.rate = {out_ch.rate_z, out_ch.rate_y, out_ch.rate_x};
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.mode, in_ch.rx_byte);
    end
  end

  initial begin
    int n;
    out_ch.ready <= 1'b0;
    out_quiet = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_gap(out_quiet);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_beat(logic mode, logic [7:0] b);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(logic [7:0] type_byte, logic [15:0] cx, logic [15:0] cy,
                            logic [15:0] cz, int zero_at);
    logic [7:0]  bytes [FRAME_LEN];
    logic [15:0] codes [isfd_pkg::NUM_AXES];
    codes[0] = cx;
    codes[1] = cy;
    codes[2] = cz;
    bytes[0] = isfd_pkg::HDR_BYTE;
    bytes[1] = type_byte;
    for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
      bytes[2 + 2 * i] = codes[i][7:0];
      bytes[3 + 2 * i] = codes[i][15:8];
    end
    for (int i = 2 + 2 * isfd_pkg::NUM_AXES; i < FRAME_LEN; i++) bytes[i] = 8'($urandom);
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == zero_at) send_beat(isfd_pkg::MODE_ZERO, 8'($urandom));
      send_beat(isfd_pkg::MODE_BYTE, bytes[i]);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(logic [isfd_pkg::SR_W-1:0] v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.sample_rate <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_rate(v);
  endtask

  task automatic random_phase(int budget);
    int         sent;
    int         r;
    int         zero_at;
    logic [7:0] t;
    logic [7:0] junk;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 4)) begin
          junk = 8'($urandom);
          if (junk == isfd_pkg::HDR_BYTE) junk = ~junk;
          send_beat(isfd_pkg::MODE_BYTE, junk);
        end
      end else if (r < 20) begin
        send_beat(isfd_pkg::MODE_ZERO, 8'($urandom));
        sent++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) t = isfd_pkg::TYPE_ACCEL;
        else if (r < 85) t = isfd_pkg::TYPE_ANGLE;
        else t = 8'($urandom);
        zero_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_LEN - 1) : -1;
        send_frame(t, rand_code(), rand_code(), rand_code(), zero_at);
        sent += FRAME_LEN;
      end
    end
  endtask

  initial begin
    sb = new();
    in_quiet = 0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= isfd_pkg::MODE_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.sample_rate <= isfd_pkg::SAMPLE_RATE_RST;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(isfd_pkg::MODE_BYTE, 8'hFF);
    send_beat(isfd_pkg::MODE_ZERO, 8'hAA);
    send_frame(isfd_pkg::TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h5555, -1);
    send_frame(isfd_pkg::TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'h0000, -1);
    send_beat(isfd_pkg::MODE_ZERO, 8'h00);

    random_phase(PHASE_BEATS);
    rate_plan = '{10'd1000, 10'd1, 10'd1023, 10'd0, 10'd1};
    rate_plan[NUM_RATES-1] = $urandom_range(2, 999);
    for (int p = 0; p < NUM_RATES; p++) begin
      write_rate(rate_plan[p]);
      random_phase(PHASE_BEATS);
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/isfd_pkg.sv
hdl/isfd_if.sv
hdl/isfd_frame_asm.sv
hdl/isfd_axis.sv
hdl/imu_serial_frame_decoder_core.sv
bench/tb_imu_serial_frame_decoder_core.sv
